// ----- rtl/core/dpmf_pkg.sv -----
// ----------------------------------------------------------------------------
// dpmf_pkg
// shared types and constants of the dual port message fifo
// ----------------------------------------------------------------------------
package dpmf_pkg;

  localparam int QUEUE_BYTES_DEF = 512;
  localparam int MAX_RESULTS     = 64;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int CHUNK_W         = 7;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CONN  = 2'd0,
    OP_MSG   = 2'd1,
    OP_DRAIN = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        port;
    logic [1:0]  connected_mask;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        final_byte;
    logic [9:0]  message_length;
    logic [6:0]  sink_accepts;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        out_port;
    logic [7:0]  out_byte;
    logic        accepted;
    logic        last_of_run;
    logic [31:0] rejected_count;
    logic [31:0] abandoned_count;
    logic [9:0]  fill_port0;
    logic [9:0]  fill_port1;
  } out_item_t;

  // decisions handed from the planner to the control
  typedef struct packed {
    logic             admit_ok;
    logic [CNT_W-1:0] drain_n;
  } plan_t;

endpackage

// ----- rtl/core/dpmf_ram.sv -----
// ----------------------------------------------------------------------------
// dpmf_ram
// byte ring storage of one port, one write and one registered read port
// ----------------------------------------------------------------------------
module dpmf_ram #(
  parameter int DEPTH = dpmf_pkg::QUEUE_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dpmf_plan.sv -----
// ----------------------------------------------------------------------------
// dpmf_plan
// admission check of a new message and size of a drain burst
// ----------------------------------------------------------------------------
module dpmf_plan #(
  parameter int QUEUE_BYTES = dpmf_pkg::QUEUE_BYTES_DEF,
  parameter int PW = $clog2(QUEUE_BYTES),
  parameter int FW = $clog2(QUEUE_BYTES + 1)
) (
  input  logic [FW-1:0]               fill [2],
  input  logic [PW-1:0]               rptr [2],
  input  logic [1:0]                  link,
  input  logic [9:0]                  length,
  input  logic                        port,
  input  logic [6:0]                  sink,
  input  logic [dpmf_pkg::CHUNK_W-1:0] chunk,
  output dpmf_pkg::plan_t             plan
);

  localparam int LW = (FW > 10) ? FW : 10;
  localparam int MW = (FW > dpmf_pkg::CNT_W) ? FW : dpmf_pkg::CNT_W;

  logic [FW-1:0] room [2];
  logic          fits [2];
  logic [FW-1:0] to_wrap;
  logic [FW-1:0] avail;
  logic [dpmf_pkg::CNT_W-1:0] lim;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      room[p] = FW'(QUEUE_BYTES) - fill[p];
      fits[p] = !link[p] || (LW'(length) <= LW'(room[p]));
    end
    plan.admit_ok = (link != 2'b00) && fits[0] && fits[1];

    // bytes up to the ring wrap, then the chunk, sink and burst limits
    to_wrap = FW'(QUEUE_BYTES) - FW'(rptr[port]);
    avail   = (fill[port] < to_wrap) ? fill[port] : to_wrap;
    lim     = dpmf_pkg::CNT_W'(dpmf_pkg::MAX_RESULTS);
    if (dpmf_pkg::CNT_W'(chunk) < lim) begin
      lim = dpmf_pkg::CNT_W'(chunk);
    end
    if (dpmf_pkg::CNT_W'(sink) < lim) begin
      lim = dpmf_pkg::CNT_W'(sink);
    end
    if (MW'(avail) < MW'(lim)) begin
      lim = dpmf_pkg::CNT_W'(avail);
    end
    plan.drain_n = link[port] ? lim : '0;
  end

endmodule

// ----- rtl/core/dual_port_message_fifo.sv -----
// ----------------------------------------------------------------------------
// dual_port_message_fifo
// two byte ring queues with connection flush, message admission and drains
// ----------------------------------------------------------------------------
// a status result is registered and appears in the cycle after its item is accepted
// a drain returns its bytes through the registered ring read and the result
// register, one byte per cycle; busy is high while the ring memory is read
// one item per cycle for updates and message bytes while not busy; a drain
// takes no new item until its burst ends; results cannot be stalled by the receiver
// reset: synchronous, clears pointers, fills, links and counters at once;
// the ring memories are not cleared and need no clearing pass
module dual_port_message_fifo #(
  parameter int QUEUE_BYTES = dpmf_pkg::QUEUE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  dpmf_pkg::in_item_t           in_item,
  output logic                         out_strobe,
  output dpmf_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [dpmf_pkg::CHUNK_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(QUEUE_BYTES);
  localparam int FW = $clog2(QUEUE_BYTES + 1);

  // control state
  dpmf_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] rp_r [2];
  logic [PW-1:0] rp_nxt [2];
  logic [FW-1:0] fill_r [2];
  logic [FW-1:0] fill_nxt [2];
  logic [1:0]    link_r, link_nxt;
  logic [31:0]   refused_r, refused_nxt;
  logic [31:0]   discarded_r, discarded_nxt;
  logic          admitted_r, admitted_nxt;
  logic [1:0]    amask_r, amask_nxt;
  logic [dpmf_pkg::CHUNK_W-1:0] chunk_r;
  logic [dpmf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic          dport_r, dport_nxt;

  // result register
  logic          strobe_r, strobe_nxt;
  logic          kind_r, kind_nxt;
  logic          oport_r, oport_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          acc_r, acc_nxt;
  logic          last_r, last_nxt;

  // memory side
  logic          we [2];
  logic [PW-1:0] waddr [2];
  logic [PW-1:0] raddr [2];
  logic [7:0]    rdata [2];
  logic [PW-1:0] rp_inc [2];
  logic [PW:0]   slot_sum [2];

  dpmf_pkg::plan_t plan;
  logic            accept;
  logic            adm_v;
  logic [1:0]      amask_v;

  assign busy   = (state_r == dpmf_pkg::ST_DRAIN);
  assign accept = start && !busy;

  dpmf_plan #(
    .QUEUE_BYTES (QUEUE_BYTES)
  ) u_plan (
    .fill   (fill_r),
    .rptr   (rp_r),
    .link   (link_r),
    .length (in_item.message_length),
    .port   (in_item.port),
    .sink   (in_item.sink_accepts),
    .chunk  (chunk_r),
    .plan   (plan)
  );

  for (genvar g = 0; g < 2; g++) begin : g_ring
    // next read slot, wrapping at the ring end
    assign rp_inc[g] = (rp_r[g] == PW'(QUEUE_BYTES - 1)) ? '0 : rp_r[g] + 1'b1;
    // during a burst read one slot ahead so a byte is ready every cycle
    assign raddr[g]  = busy ? rp_inc[g] : rp_r[g];
    // tail slot: read pointer plus fill, folded once
    assign slot_sum[g] = (PW + 1)'(rp_r[g]) + (PW + 1)'(fill_r[g]);
    assign waddr[g]    = (slot_sum[g] >= (PW + 1)'(QUEUE_BYTES)) ?
                         PW'(slot_sum[g] - (PW + 1)'(QUEUE_BYTES)) : PW'(slot_sum[g]);

    dpmf_ram #(
      .DEPTH (QUEUE_BYTES),
      .AW    (PW)
    ) u_ram (
      .clk   (clk),
      .we    (we[g]),
      .waddr (waddr[g]),
      .wdata (in_item.data_byte),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    link_nxt      = link_r;
    refused_nxt   = refused_r;
    discarded_nxt = discarded_r;
    admitted_nxt  = admitted_r;
    amask_nxt     = amask_r;
    cnt_nxt       = cnt_r;
    dport_nxt     = dport_r;
    strobe_nxt    = 1'b0;
    kind_nxt      = 1'b0;
    oport_nxt     = 1'b0;
    obyte_nxt     = '0;
    acc_nxt       = 1'b0;
    last_nxt      = 1'b1;
    adm_v         = admitted_r;
    amask_v       = amask_r;
    we[0]         = 1'b0;
    we[1]         = 1'b0;

    case (state_r)
      dpmf_pkg::ST_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          case (in_item.operation)
            dpmf_pkg::OP_CONN: begin
              // flush every port whose link state changes
              for (int p = 0; p < 2; p++) begin
                if (in_item.connected_mask[p] != link_r[p]) begin
                  discarded_nxt = discarded_nxt + 32'(fill_r[p]);
                  rp_nxt[p]     = '0;
                  fill_nxt[p]   = '0;
                  amask_nxt[p]  = 1'b0;
                  link_nxt[p]   = in_item.connected_mask[p];
                end
              end
            end
            dpmf_pkg::OP_MSG: begin
              // a first byte opens a fresh admission decision
              if (in_item.first_byte) begin
                adm_v   = 1'b0;
                amask_v = 2'b00;
                if (in_item.message_length != '0) begin
                  if (plan.admit_ok) begin
                    adm_v   = 1'b1;
                    amask_v = link_r;
                  end else begin
                    refused_nxt = refused_r + 32'd1;
                  end
                end
              end
              // append to each admitted port that still has a free slot
              for (int p = 0; p < 2; p++) begin
                if (adm_v && amask_v[p] && (fill_r[p] < FW'(QUEUE_BYTES))) begin
                  we[p]       = 1'b1;
                  fill_nxt[p] = fill_r[p] + 1'b1;
                end
              end
              admitted_nxt = adm_v;
              amask_nxt    = amask_v;
              if (in_item.final_byte) begin
                acc_nxt      = adm_v;
                admitted_nxt = 1'b0;
                amask_nxt    = 2'b00;
              end
            end
            dpmf_pkg::OP_DRAIN: begin
              // a nonempty burst goes out of the memory and skips the status result
              if (plan.drain_n != '0) begin
                strobe_nxt = 1'b0;
                state_nxt  = dpmf_pkg::ST_DRAIN;
                cnt_nxt    = plan.drain_n;
                dport_nxt  = in_item.port;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dpmf_pkg::ST_DRAIN: begin
        // one byte per cycle from the registered read data
        strobe_nxt        = 1'b1;
        kind_nxt          = 1'b1;
        oport_nxt         = dport_r;
        obyte_nxt         = rdata[dport_r];
        last_nxt          = (cnt_r == dpmf_pkg::CNT_W'(1));
        rp_nxt[dport_r]   = rp_inc[dport_r];
        fill_nxt[dport_r] = fill_r[dport_r] - 1'b1;
        cnt_nxt           = cnt_r - 1'b1;
        if (cnt_r == dpmf_pkg::CNT_W'(1)) begin
          state_nxt = dpmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dpmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpmf_pkg::ST_IDLE;
      rp_r[0]     <= '0;
      rp_r[1]     <= '0;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      link_r      <= '0;
      refused_r   <= '0;
      discarded_r <= '0;
      admitted_r  <= 1'b0;
      amask_r     <= '0;
      chunk_r     <= dpmf_pkg::CHUNK_RESET;
      cnt_r       <= '0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      link_r      <= link_nxt;
      refused_r   <= refused_nxt;
      discarded_r <= discarded_nxt;
      admitted_r  <= admitted_nxt;
      amask_r     <= amask_nxt;
      cnt_r       <= cnt_nxt;
      strobe_r    <= strobe_nxt;
      if (cfg_we) begin
        chunk_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dport_r <= dport_nxt;
    kind_r  <= kind_nxt;
    oport_r <= oport_nxt;
    obyte_r <= obyte_nxt;
    acc_r   <= acc_nxt;
    last_r  <= last_nxt;
  end

  // counters and fills are live: they already hold the value after the result
  assign out_strobe               = strobe_r;
  assign out_item.kind            = kind_r;
  assign out_item.out_port        = oport_r;
  assign out_item.out_byte        = obyte_r;
  assign out_item.accepted        = acc_r;
  assign out_item.last_of_run     = last_r;
  assign out_item.rejected_count  = refused_r;
  assign out_item.abandoned_count = discarded_r;
  assign out_item.fill_port0      = 10'(fill_r[0]);
  assign out_item.fill_port1      = 10'(fill_r[1]);

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FW'(QUEUE_BYTES)) && (fill_r[1] <= FW'(QUEUE_BYTES)))
    else $error("fill above queue size");

  a_unlinked_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (link_r[0] || fill_r[0] == '0) && (link_r[1] || fill_r[1] == '0))
    else $error("bytes queued on a disconnected port");

  a_admit_in_link: assert property (@(posedge clk) disable iff (!rst_n)
    (amask_r & ~link_r) == 2'b00)
    else $error("admit mask outside link mask");

  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (cnt_r != '0) && (fill_r[dport_r] >= FW'(cnt_r)))
    else $error("burst longer than queued bytes");

  a_burst_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_strobe) |-> out_item.kind && (out_item.out_port == dport_r))
    else $error("status result inside a burst");
`endif

endmodule
